// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the scheduler rtl
// no dependencies; empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ETS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ETS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ets_pkg.sv =====
// types and constants of the event tick scheduler
// no dependencies
package ets_pkg;

  localparam int TICK_W         = 64;
  localparam int ID_W           = 10;
  localparam int ENTITY_DEFAULT = 64;
  localparam int RAM_W          = 1 + 2 * TICK_W;

  typedef enum logic [2:0] {
    CMD_SCHEDULE = 3'd0,
    CMD_CANCEL   = 3'd1,
    CMD_POP      = 3'd2,
    CMD_PEEK     = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_SHIFT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_INSERT
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] due;
    logic [TICK_W-1:0] stamp;
  } cell_t;

  typedef struct packed {
    cell_op_e          op;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] due;
    logic [TICK_W-1:0] stamp;
  } cell_op_t;

  typedef struct packed {
    logic              pend;
    logic [TICK_W-1:0] due;
    logic [TICK_W-1:0] stamp;
  } ent_rec_t;

  localparam cell_t CELL_EMPTY = '0;

endpackage

// ===== hw/rtl/ets_if.sv =====
// command and result channel interfaces of the event tick scheduler
// no dependencies
interface ets_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [5:0]  entity_id;
  logic [31:0] delay_ticks;

  modport source (output valid, command, entity_id, delay_ticks, input ready);
  modport sink (input valid, command, entity_id, delay_ticks, output ready);
endinterface

interface ets_res_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [5:0]  result_entity;
  logic [63:0] result_tick;
  logic [63:0] now_tick;

  modport source (output valid, found, result_entity, result_tick, now_tick, input ready);
  modport sink (input valid, found, result_entity, result_tick, now_tick, output ready);
endinterface

// ===== hw/rtl/ets_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module ets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/ets_cell.sv =====
// one cell of the sorted event chain: holds one pending entry
// depends on ets_pkg
module ets_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ets_pkg::cell_op_t op_i,
  input  ets_pkg::cell_t    left_i,
  input  logic             left_gt_i,
  input  ets_pkg::cell_t    right_i,
  output ets_pkg::cell_t    data_o,
  output logic             gt_o
);
  import ets_pkg::*;

  logic              valid_q;
  logic [ID_W-1:0]   id_q;
  logic [TICK_W-1:0] due_q;
  logic [TICK_W-1:0] stamp_q;
  cell_t             cell_q;
  cell_t             cell_d;
  cell_t             new_cell;
  logic              ge;

  assign cell_q   = '{valid: valid_q, id: id_q, due: due_q, stamp: stamp_q};
  assign new_cell = '{valid: 1'b1, id: op_i.id, due: op_i.due, stamp: op_i.stamp};
  assign gt_o     = !valid_q || (due_q > op_i.due);
  assign ge       = valid_q && ({due_q, stamp_q} >= {op_i.due, op_i.stamp});

  always_comb begin
    cell_d = cell_q;
    case (op_i.op)
      OP_INSERT: begin
        if (gt_o) begin
          cell_d = left_gt_i ? left_i : new_cell;
        end
      end
      OP_REMOVE: begin
        if (ge) begin
          cell_d = right_i;
        end
      end
      OP_SHIFT: cell_d = right_i;
      default: cell_d = cell_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= cell_d.id;
    due_q   <= cell_d.due;
    stamp_q <= cell_d.stamp;
  end

  assign data_o = cell_q;
endmodule

// ===== hw/rtl/event_tick_scheduler.sv =====
// event tick scheduler top level: sequencer, entity table and the cell chain
// depends on ets_pkg, ets_if, ets_ram, ets_cell and assert_macros.svh
//
// Pending events sit in a chain of ENTITY_COUNT cells kept sorted by due
// tick, earlier schedules first among equal ticks, so the earliest event is
// always in the head cell. A per-entity table in one ram holds the pending
// flag, due tick and order stamp for query and for finding the old entry on
// cancel or reschedule. Each command is accepted in ST_IDLE and looked up in
// ST_LOOK, where pop, peek, cancel, query and unknown commands finish; a
// schedule also drops any earlier entry from the chain in ST_LOOK and then
// inserts sorted in ST_INSERT, set by the single ram read port and the chain
// doing one shift per cycle. One result is given per command and is held in
// an output register, stalling the sequencer only while it is not taken.
// After reset the table is cleared one entry per cycle until all ENTITY_COUNT
// entries are written, and no command is accepted meanwhile.
module event_tick_scheduler #(
  parameter int ENTITY_COUNT = ets_pkg::ENTITY_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  ets_cmd_if.sink        cmd_i,
  ets_res_if.source      res_o
);
  import ets_pkg::*;

  localparam int IW = $clog2(ENTITY_COUNT);
  localparam int XW = ((IW > 6) ? IW : 6) + 1;

  state_e            state_q, state_d;
  logic [IW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [2:0]        cmd_q;
  logic [5:0]        ent_q;
  logic [31:0]       delay_q;
  logic [TICK_W-1:0] now_q, now_d;
  logic [TICK_W-1:0] stamp_q, stamp_d;

  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [5:0]        out_ent_q, out_ent_d;
  logic [TICK_W-1:0] out_tick_q, out_tick_d;

  logic              accept;
  logic              slot_free;
  logic              in_range;
  logic [XW-1:0]     ent_x;
  logic [XW-1:0]     in_ent_x;
  logic [TICK_W-1:0] new_due;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  ent_rec_t          ram_wdata;
  ent_rec_t          ram_rdata;

  cell_op_t          op;
  cell_t             cells [ENTITY_COUNT];
  logic              gts [ENTITY_COUNT];
  cell_t             head;

  assign accept    = cmd_i.valid && cmd_i.ready;
  assign slot_free = !out_valid_q || res_o.ready;
  assign ent_x     = XW'(ent_q);
  assign in_ent_x  = XW'(cmd_i.entity_id);
  assign in_range  = ent_x < XW'(ENTITY_COUNT);
  assign new_due   = now_q + TICK_W'(delay_q);
  assign head      = cells[0];
  assign cmd_i.ready = (state_q == ST_IDLE);

  ets_ram #(
    .WIDTH (RAM_W),
    .DEPTH (ENTITY_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_ent_x[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  for (genvar i = 0; i < ENTITY_COUNT; i++) begin : g_chain
    cell_t left;
    cell_t right;
    logic  left_gt;
    if (i == 0) begin : g_first
      assign left    = CELL_EMPTY;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left    = cells[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == ENTITY_COUNT - 1) begin : g_last
      assign right = CELL_EMPTY;
    end else begin : g_inner
      assign right = cells[i+1];
    end
    ets_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (op),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .data_o    (cells[i]),
      .gt_o      (gts[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    now_d       = now_q;
    stamp_d     = stamp_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_found_d = out_found_q;
    out_ent_d   = out_ent_q;
    out_tick_d  = out_tick_q;
    ram_we      = 1'b0;
    ram_waddr   = ent_x[IW-1:0];
    ram_wdata   = '0;
    op          = '{op: OP_NONE, id: ID_W'(ent_x), due: new_due, stamp: stamp_q};

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == IW'(ENTITY_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd_q == CMD_SCHEDULE && in_range) begin
          // drop the earlier entry of this entity before inserting
          if (ram_rdata.pend) begin
            op = '{op: OP_REMOVE, id: ID_W'(ent_x), due: ram_rdata.due,
                   stamp: ram_rdata.stamp};
          end
          state_d = ST_INSERT;
        end else if (slot_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_ent_d   = 6'd0;
          out_tick_d  = '0;
          case (cmd_q)
            CMD_SCHEDULE: out_ent_d = ent_q;
            CMD_CANCEL: begin
              out_ent_d = ent_q;
              if (in_range && ram_rdata.pend) begin
                op = '{op: OP_REMOVE, id: ID_W'(ent_x), due: ram_rdata.due,
                       stamp: ram_rdata.stamp};
                ram_we    = 1'b1;
                ram_wdata = '{pend: 1'b0, due: ram_rdata.due, stamp: ram_rdata.stamp};
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (head.valid) begin
                out_found_d = 1'b1;
                out_ent_d   = 6'(head.id);
                out_tick_d  = head.due;
                if (cmd_q == CMD_POP) begin
                  op.op     = OP_SHIFT;
                  ram_we    = 1'b1;
                  ram_waddr = head.id[IW-1:0];
                  ram_wdata = '{pend: 1'b0, due: head.due, stamp: head.stamp};
                  now_d     = head.due;
                end
              end
            end
            CMD_QUERY: begin
              out_ent_d = ent_q;
              if (in_range && ram_rdata.pend) begin
                out_found_d = 1'b1;
                out_tick_d  = ram_rdata.due;
              end
            end
            default: out_ent_d = 6'd0;
          endcase
        end
      end
      ST_INSERT: begin
        if (slot_free) begin
          op          = '{op: OP_INSERT, id: ID_W'(ent_x), due: new_due, stamp: stamp_q};
          ram_we      = 1'b1;
          ram_wdata   = '{pend: 1'b1, due: new_due, stamp: stamp_q};
          stamp_d     = stamp_q + 1'b1;
          out_valid_d = 1'b1;
          out_found_d = 1'b0;
          out_ent_d   = ent_q;
          out_tick_d  = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      now_q       <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      now_q       <= now_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_i.command;
      ent_q   <= cmd_i.entity_id;
      delay_q <= cmd_i.delay_ticks;
    end
    out_found_q <= out_found_d;
    out_ent_q   <= out_ent_d;
    out_tick_q  <= out_tick_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.found         = out_found_q;
  assign res_o.result_entity = out_ent_q;
  assign res_o.result_tick   = out_tick_q;
  assign res_o.now_tick      = now_q;

  `include "assert_macros.svh"

  `ETS_ASSERT_IMPLY(a_no_accept_in_clear, clk_i, rst_ni, state_q == ST_CLEAR, !cmd_i.ready)
  `ETS_ASSERT_NEXT(a_accept_to_look, clk_i, rst_ni, accept, state_q == ST_LOOK)
  `ETS_ASSERT_NEXT(a_pop_sets_now, clk_i, rst_ni, op.op == OP_SHIFT, now_q == $past(head.due))
  `ETS_ASSERT_NEXT(a_stamp_on_insert, clk_i, rst_ni, op.op != OP_INSERT, $stable(stamp_q))
endmodule

// ===== sim/event_tick_scheduler_test.sv =====
// testbench of the event tick scheduler: directed table then random commands
// depends on ets_pkg, ets_if and the event_tick_scheduler rtl
`timescale 1ns / 100ps

module event_tick_scheduler_test;
  import ets_pkg::*;

  localparam int NENT = 64;
  localparam int RANDOM_CMDS = 730;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]  cmd;
    logic [5:0]  ent;
    logic [31:0] delay;
  } sched_cmd_t;

  typedef struct packed {
    logic        found;
    logic [5:0]  ent;
    logic [63:0] tick;
    logic [63:0] now;
  } sched_res_t;

  typedef struct {
    sched_cmd_t c;
    bit         typed;
    sched_res_t r;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit failed = 1'b0;
  bit quiet = 1'b0;
  bit hold_sink = 1'b0;
  int unsigned hold_cycles = 0;
  longint unsigned cycle_count = 0;

  ets_cmd_if cmd_if ();
  ets_res_if res_if ();

  event_tick_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  bit          sch_pending [NENT];
  logic [63:0] sch_due     [NENT];
  logic [63:0] sch_stamp   [NENT];
  logic [63:0] sch_now;
  logic [63:0] sch_next_stamp;
  sched_res_t  awaited_results[$];

  function automatic sched_res_t schedule_step(sched_cmd_t c);
    sched_res_t r;
    int best;
    r = '{1'b0, 6'd0, 64'd0, 64'd0};
    best = -1;
    case (c.cmd)
      CMD_SCHEDULE: begin
        r.ent = c.ent;
        sch_pending[c.ent] = 1'b1;
        sch_due[c.ent] = sch_now + 64'(c.delay);
        sch_stamp[c.ent] = sch_next_stamp;
        sch_next_stamp++;
      end
      CMD_CANCEL: begin
        r.ent = c.ent;
        sch_pending[c.ent] = 1'b0;
      end
      CMD_POP, CMD_PEEK: begin
        for (int i = 0; i < NENT; i++) begin
          if (sch_pending[i] && (best < 0 || sch_due[i] < sch_due[best] ||
              (sch_due[i] == sch_due[best] && sch_stamp[i] < sch_stamp[best])))
            best = i;
        end
        if (best >= 0) begin
          r.found = 1'b1;
          r.ent = 6'(best);
          r.tick = sch_due[best];
          if (c.cmd == CMD_POP) begin
            sch_pending[best] = 1'b0;
            sch_now = sch_due[best];
          end
        end
      end
      CMD_QUERY: begin
        r.ent = c.ent;
        if (sch_pending[c.ent]) begin
          r.found = 1'b1;
          r.tick = sch_due[c.ent];
        end
      end
      default: ;
    endcase
    r.now = sch_now;
    return r;
  endfunction

  task automatic send_cmd(sched_cmd_t c);
    cmd_if.valid <= 1'b1;
    cmd_if.command <= c.cmd;
    cmd_if.entity_id <= c.ent;
    cmd_if.delay_ticks <= c.delay;
    do @(posedge clk_i); while (!cmd_if.ready);
    awaited_results.push_back(schedule_step(c));
  endtask

  task automatic source_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 11);
      cmd_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic sched_cmd_t random_cmd();
    sched_cmd_t c;
    int k;
    k = $urandom_range(0, 99);
    c.ent = 6'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) c.ent = 6'($urandom);
    case ($urandom_range(0, 3))
      0: c.delay = $urandom;
      1: c.delay = 32'($urandom_range(0, 3));
      default: c.delay = 32'($urandom_range(0, 1000));
    endcase
    if (k < 40) c.cmd = CMD_SCHEDULE;
    else if (k < 50) c.cmd = CMD_CANCEL;
    else if (k < 72) c.cmd = CMD_POP;
    else if (k < 82) c.cmd = CMD_PEEK;
    else if (k < 96) c.cmd = CMD_QUERY;
    else c.cmd = 3'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // directed stimulus; typed rows can be read straight off the behaviour
  table_row_t directed[] = '{
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b1, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_PEEK, 6'd9, 32'd0}, 1'b1, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_QUERY, 6'd63, 32'd0}, 1'b1, '{1'b0, 6'd63, 64'd0, 64'd0}},
    '{'{CMD_CANCEL, 6'd5, 32'd0}, 1'b1, '{1'b0, 6'd5, 64'd0, 64'd0}},
    '{'{3'd5, 6'd1, 32'd1}, 1'b1, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{3'd7, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd63, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 6'd63, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd0, 32'd0}, 1'b1, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd1, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_PEEK, 6'd0, 32'd0}, 1'b1, '{1'b1, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_QUERY, 6'd63, 32'd0}, 1'b1, '{1'b1, 6'd63, 64'hFFFF_FFFF, 64'd0}},
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd1, 32'd7}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_CANCEL, 6'd1, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_CANCEL, 6'd1, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_QUERY, 6'd1, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd42, 32'hFFFF_FFFF}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_SCHEDULE, 6'd21, 32'hFFFF_FFFF}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}},
    '{'{CMD_POP, 6'd0, 32'd0}, 1'b0, '{1'b0, 6'd0, 64'd0, 64'd0}}
  };

  initial begin
    sched_res_t want;
    sched_cmd_t c;
    cmd_if.valid = 1'b0;
    cmd_if.command = CMD_SCHEDULE;
    cmd_if.entity_id = '0;
    cmd_if.delay_ticks = '0;
    for (int i = 0; i < NENT; i++) begin
      sch_pending[i] = 1'b0;
      sch_due[i] = '0;
      sch_stamp[i] = '0;
    end
    sch_now = '0;
    sch_next_stamp = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) begin
      send_cmd(directed[i].c);
      if (directed[i].typed) begin
        want = awaited_results[$];
        if (want != directed[i].r) begin
          $error("table row %0d: typed result differs from predictor", i);
          failed = 1'b1;
        end
      end
      source_gap();
    end

    // long receiver hold so the block backs up and stalls commands
    hold_cycles = 300;
    hold_sink <= 1'b1;
    for (int i = 0; i < 40; i++) send_cmd(random_cmd());

    // sender pause until every result has arrived
    cmd_if.valid <= 1'b0;
    wait_drained();

    // reschedule and cancel one entity at the largest delay, querying it after the last schedule
    for (int j = 0; j < 6; j++) begin
      c = '{CMD_SCHEDULE, 6'd50, 32'hFFFF_FFFF};
      send_cmd(c);
      c = '{CMD_CANCEL, 6'd50, 32'd0};
      if (j == 5) c.cmd = CMD_QUERY;
      send_cmd(c);
    end

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (i == RANDOM_CMDS - 120) quiet = 1'b1;
      send_cmd(random_cmd());
      source_gap();
    end
    cmd_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (!failed) $display("event_tick_scheduler: match");
    else $display("event_tick_scheduler: mismatch");
    $finish;
  end

  // result sink with random stalls and one long hold
  initial begin
    int n;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        res_if.ready <= 1'b0;
        if (hold_cycles > 0) hold_cycles--;
        else hold_sink = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        res_if.ready <= 1'b0;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sched_res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with no command outstanding");
        failed = 1'b1;
      end else begin
        want = awaited_results.pop_front();
        if (res_if.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, res_if.found);
          failed = 1'b1;
        end
        if (res_if.result_entity !== want.ent) begin
          $error("result_entity: expected %0d, actual %0d", want.ent,
                 res_if.result_entity);
          failed = 1'b1;
        end
        if (res_if.result_tick !== want.tick) begin
          $error("result_tick: expected %0h, actual %0h", want.tick,
                 res_if.result_tick);
          failed = 1'b1;
        end
        if (res_if.now_tick !== want.now) begin
          $error("now_tick: expected %0h, actual %0h", want.now, res_if.now_tick);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("event_tick_scheduler: mismatch");
      $finish;
    end
  end

endmodule
